### design/assert_macros.svh
// assertion macros used by the top rtl file of the k-way merge block
// no dependencies; pulled in by include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/kwm_pkg.sv
// shared types and constants of the k-way sorted merge block
// no dependencies; imported by kwm_front, kwm_back and k_way_sorted_merge
`default_nettype none

package kwm_pkg;

    // sizes fixed by the transaction fields
    localparam int WAYS_DEFAULT = 16;
    localparam int WAY_FIELD_W  = 4;
    localparam int VALUE_W      = 32;
    localparam int CNT_W        = 5;

    localparam logic [CNT_W-1:0] ACTIVE_WAYS_RESET = 5'd16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input action codes
    localparam logic ACTION_DELIVER = 1'b0;
    localparam logic ACTION_EXHAUST = 1'b1;

    // classified operation codes handed from front to back
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_DELIVER = 2'd1;
    localparam logic [1:0] OP_EXHAUST = 2'd2;

    typedef struct packed {
        logic                      action;
        logic [WAY_FIELD_W-1:0]    way;
        logic signed [VALUE_W-1:0] value;
    } item_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [WAY_FIELD_W-1:0]    source_way;
        logic                      merge_done;
    } item_out_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [WAY_FIELD_W-1:0]    way;
        logic signed [VALUE_W-1:0] value;
    } work_t;

endpackage

`default_nettype wire

### design/kwm_front.sv
// front end of the merge: accepts input transactions, classifies them and queues them
// depends on kwm_pkg
`default_nettype none

module kwm_front #(
    parameter int WAYS = kwm_pkg::WAYS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire kwm_pkg::item_in_t          in_data,
    input  wire logic [kwm_pkg::CNT_W-1:0]  active_ways,
    output logic                            q_valid,
    input  wire logic                       q_pop,
    output kwm_pkg::work_t                  q_item
);
    import kwm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              in_range;
    work_t             item_cls;

    // classify the incoming transaction against the active way count
    always_comb
    begin
        in_range = (32'(in_data.way) < WAYS) && ({1'b0, in_data.way} < active_ways);
        item_cls.way   = in_data.way;
        item_cls.value = in_data.value;
        if (!in_range)
        begin
            item_cls.op = OP_NONE;
        end
        else
        begin
            unique case (in_data.action)
                ACTION_DELIVER: item_cls.op = OP_DELIVER;
                ACTION_EXHAUST: item_cls.op = OP_EXHAUST;
                default:        item_cls.op = OP_NONE;
            endcase
        end
    end

    // queue occupancy and pointers
    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_cls;
        end
    end

endmodule

`default_nettype wire

### design/kwm_back.sv
// back end of the merge: head registers, pairwise order matrix, minimum select
// and the output register; depends on kwm_pkg
`default_nettype none

module kwm_back #(
    parameter int WAYS = kwm_pkg::WAYS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [kwm_pkg::CNT_W-1:0]  active_ways,
    input  wire logic                       q_valid,
    input  wire kwm_pkg::work_t             q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output kwm_pkg::item_out_t              out_data
);
    import kwm_pkg::*;

    // only ways that the way field can address ever hold a head
    localparam int REACH = (WAYS < (1 << WAY_FIELD_W)) ? WAYS : (1 << WAY_FIELD_W);
    localparam int IDX_W = $clog2(REACH);

    logic signed [VALUE_W-1:0] head_reg [REACH];
    logic [REACH-1:0]          beats_reg [REACH];
    logic [REACH-1:0]          beats_eff [REACH];
    logic [REACH-1:0]          valid_reg, valid_next;
    logic [REACH-1:0]          fin_reg, fin_next;
    logic [REACH-1:0]          act, new_row, w_hot, valid_upd, fin_upd, part, win;
    logic [IDX_W-1:0]          w;
    logic                      wr, exh, over, ready, any, fire;
    logic signed [VALUE_W-1:0] best_value;
    logic [IDX_W-1:0]          best_idx;
    logic                      out_valid_reg, out_valid_next;
    item_out_t                 out_reg, out_next;

    // active ways within the addressable range
    for (genvar gi = 0; gi < REACH; gi++)
    begin : g_act
        assign act[gi] = (32'(active_ways) > 32'(gi));
    end

    // active ways that no input can reach never become ready
    assign over = (32'(active_ways) > REACH) && (WAYS > REACH);

    // apply the queued operation and order the new head against all others
    always_comb
    begin
        w     = q_item.way[IDX_W-1:0];
        w_hot = REACH'(1) << w;
        exh   = (q_item.op == OP_EXHAUST);
        wr    = (q_item.op == OP_DELIVER) && !valid_reg[w] && !fin_reg[w];
        for (int j = 0; j < REACH; j++)
        begin
            new_row[j] = ($signed(q_item.value) < head_reg[j]) ||
                         (($signed(q_item.value) == head_reg[j]) && (IDX_W'(j) > w));
        end
        valid_upd = valid_reg | (wr ? w_hot : '0);
        fin_upd   = fin_reg | (exh ? w_hot : '0);
        part      = valid_upd & act;
        ready     = (&(part | fin_upd | ~act)) && !over;
        any       = |part;
    end

    // order matrix after the write: row of the new head and its column flip
    always_comb
    begin
        for (int i = 0; i < REACH; i++)
        begin
            for (int j = 0; j < REACH; j++)
            begin
                if (i == j)
                begin
                    beats_eff[i][j] = 1'b1;
                end
                else if (wr && (IDX_W'(i) == w))
                begin
                    beats_eff[i][j] = new_row[j];
                end
                else if (wr && (IDX_W'(j) == w))
                begin
                    beats_eff[i][j] = !new_row[i];
                end
                else
                begin
                    beats_eff[i][j] = beats_reg[i][j];
                end
            end
        end
    end

    // winner beats every other participating head; at most one such way
    always_comb
    begin
        best_value = '0;
        best_idx   = '0;
        for (int i = 0; i < REACH; i++)
        begin
            win[i] = part[i] && (&(~part | beats_eff[i]));
            if (win[i])
            begin
                best_value = best_value |
                             ((wr && (IDX_W'(i) == w)) ? $signed(q_item.value) : head_reg[i]);
                best_idx   = best_idx | IDX_W'(i);
            end
        end
    end

    // step handshake against the output register
    assign fire  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = fire;

    always_comb
    begin
        valid_next     = valid_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            valid_next = valid_upd;
            fin_next   = fin_upd;
            if (ready)
            begin
                out_valid_next = 1'b1;
                if (any)
                begin
                    valid_next            = valid_upd & ~win;
                    out_next.merged_value = best_value;
                    out_next.source_way   = WAY_FIELD_W'(best_idx);
                    out_next.merge_done   = 1'b0;
                end
                else
                begin
                    fin_next              = '0;
                    out_next.merged_value = '0;
                    out_next.source_way   = '0;
                    out_next.merge_done   = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // head values, order matrix and result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (fire && wr)
        begin
            head_reg[w] <= $signed(q_item.value);
            for (int i = 0; i < REACH; i++)
            begin
                beats_reg[i] <= beats_eff[i];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### design/k_way_sorted_merge.sv
// Merges up to WAYS ascending signed lists (no more than the way field can address)
// into one ascending stream. Each input transaction refills one way or marks it
// exhausted; once every active way holds a head or is finished the smallest head leaves
// with its way (ties to the lowest way), and when all active ways are finished a done
// marker leaves and the finished marks clear. The block sustains one input and one
// output transaction per cycle; an accepted input is written into a queue slot, and the
// back-end step that consumes it writes any result into the output register. That rate
// comes from the combinational back-end step: a bank of parallel comparators orders a
// new head against every stored head, a pairwise order matrix keeps those results, and
// the minimum falls out of an AND reduction over the matrix rows. A stalled output
// holds the back end and the two-entry queue then fills and stalls the input.
// active_ways may only be written while the block is idle; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module k_way_sorted_merge #(
    parameter int WAYS = kwm_pkg::WAYS_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire kwm_pkg::item_in_t          in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output kwm_pkg::item_out_t              out_data,
    input  wire logic                       cfg_we,
    input  wire logic [kwm_pkg::CNT_W-1:0]  cfg_wdata
);
    import kwm_pkg::*;

    logic [CNT_W-1:0] active_ways_reg;
    logic             q_valid;
    logic             q_pop;
    work_t            q_item;
    logic             done_zero;
    logic             src_active;

    // active way count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_ways_reg <= ACTIVE_WAYS_RESET;
        end
        else if (cfg_we)
        begin
            active_ways_reg <= cfg_wdata;
        end
    end

    // classify and queue
    kwm_front #(
        .WAYS (WAYS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .active_ways (active_ways_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item)
    );

    // heads, minimum select and output register
    kwm_back #(
        .WAYS (WAYS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .active_ways (active_ways_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    // terms checked by the assertions
    assign done_zero  = (out_data.merged_value == '0) && (out_data.source_way == '0);
    assign src_active = ({1'b0, out_data.source_way} < active_ways_reg);

    // done marker carries zero value fields
    `ASSERT_IMPLIES(a_done_zero, clk, rst_n, out_valid && out_data.merge_done, done_zero)

    // a merged value always comes from an active way
    `ASSERT_IMPLIES(a_src_active, clk, rst_n, out_valid && !out_data.merge_done, src_active)

    // back end only steps when the output register can take the result
    `ASSERT_IMPLIES(a_pop_room, clk, rst_n, q_pop, q_valid && (!out_valid || out_ready))

    // an empty queue cannot be full in the next cycle
    `ASSERT_NEXT(a_queue_room, clk, rst_n, !q_valid, in_ready)

endmodule

`default_nettype wire

### bench/kwm_checker.sv
`timescale 1ns / 100ps
// checker of the k-way merge: watches the input, output and register ports,
// predicts each merged result and compares it with what leaves the block
// depends on kwm_pkg for the transaction types and action codes

module kwm_checker #(
    parameter int WAYS = kwm_pkg::WAYS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  kwm_pkg::item_in_t         in_data,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  kwm_pkg::item_out_t        out_data,
    input  logic                      cfg_we,
    input  logic [kwm_pkg::CNT_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        due_count
);
    import kwm_pkg::*;

    // shadow of the merge state
    logic [CNT_W-1:0]          way_count = ACTIVE_WAYS_RESET;
    logic signed [VALUE_W-1:0] head_val [WAYS];
    logic [WAYS-1:0]           head_full = '0;
    logic [WAYS-1:0]           way_fin = '0;
    item_out_t                 merged_due [$];

    initial fail_count = 0;
    initial due_count = 0;

    // apply one input transaction, return 1 when it releases a result
    function automatic bit next_merged(input item_in_t it, output item_out_t res);
        int  n;
        int  best;
        bit  all_ready;
        bit  any_head;
        n = (way_count < WAYS) ? int'(way_count) : WAYS;
        res = '0;
        best = 0;
        all_ready = 1'b1;
        any_head = 1'b0;

        // refill or exhaust, inactive ways are ignored
        if (it.way < n) begin
            if (it.action == ACTION_EXHAUST)
                way_fin[it.way] = 1'b1;
            else if (!head_full[it.way] && !way_fin[it.way]) begin
                head_val[it.way] = it.value;
                head_full[it.way] = 1'b1;
            end
        end

        // every active way needs a head or a finished mark
        for (int i = 0; i < n; i++)
            if (!head_full[i] && !way_fin[i])
                all_ready = 1'b0;
        if (!all_ready)
            return 1'b0;

        // smallest head, ties to the lowest way
        for (int i = 0; i < n; i++) begin
            if (head_full[i]) begin
                if (!any_head || head_val[i] < head_val[best])
                    best = i;
                any_head = 1'b1;
            end
        end

        if (any_head) begin
            head_full[best] = 1'b0;
            res.merged_value = head_val[best];
            res.source_way = best[WAY_FIELD_W-1:0];
            res.merge_done = 1'b0;
        end
        else begin
            way_fin = '0;
            res.merge_done = 1'b1;
        end
        return 1'b1;
    endfunction

    // predict on accepted inputs, compare accepted outputs
    always @(posedge clk or negedge rst_n) begin : watch
        item_out_t pred;
        item_out_t seen;
        if (!rst_n) begin
            way_count = ACTIVE_WAYS_RESET;
            head_full = '0;
            way_fin = '0;
            merged_due.delete();
        end
        else begin
            if (cfg_we)
                way_count = cfg_wdata;
            if (in_valid && in_ready)
                if (next_merged(in_data, pred))
                    merged_due.insert(merged_due.size(), pred);
            if (out_valid && out_ready) begin
                seen = out_data;
                if (merged_due.size() == 0) begin
                    $error("unexpected result: merged_value %0d source_way %0d merge_done %0b",
                           seen.merged_value, seen.source_way, seen.merge_done);
                    fail_count++;
                end
                else begin
                    pred = merged_due.pop_front();
                    if (seen.merged_value !== pred.merged_value) begin
                        $error("merged_value: expected %0d, got %0d",
                               pred.merged_value, seen.merged_value);
                        fail_count++;
                    end
                    if (seen.source_way !== pred.source_way) begin
                        $error("source_way: expected %0d, got %0d",
                               pred.source_way, seen.source_way);
                        fail_count++;
                    end
                    if (seen.merge_done !== pred.merge_done) begin
                        $error("merge_done: expected %0b, got %0b",
                               pred.merge_done, seen.merge_done);
                        fail_count++;
                    end
                end
            end
        end
        due_count = merged_due.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// testbench top of the k-way merge: clock, reset, stimulus and the verdict
// depends on kwm_pkg, the k_way_sorted_merge block and kwm_checker

module tb_top;
    import kwm_pkg::*;

    localparam int     WAYS          = WAYS_DEFAULT;
    localparam int     RANDOM_ITEMS  = 700;
    localparam int     LIMIT_CYCLES  = 400000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     DRAIN_CYCLES  = 20000;
    localparam longint VALUE_MAX     = 64'sd2147483647;
    localparam longint VALUE_MIN     = -64'sd2147483648;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    item_in_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    item_out_t        out_data;
    logic             cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = ACTIVE_WAYS_RESET;

    int fail_count;
    int due_count;
    int items_sent = 0;
    int done_seen = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    // ways emitted by the block that wait for their next element
    logic [WAY_FIELD_W-1:0] refill_q [$];

    // per-way sorted list under construction
    longint cur_val [WAYS];
    int     rem [WAYS];
    int     stride [WAYS];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    k_way_sorted_merge #(.WAYS(WAYS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    kwm_checker #(.WAYS(WAYS)) merge_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    // follow the merged stream to know which way to refill
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (out_data.merge_done)
                done_seen++;
            else
                refill_q.insert(refill_q.size(), out_data.source_way);
        end
    end

    // receiver stalls, mostly short, a few long
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    // run limit
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic item_in_t mk_item(input logic act, input int w,
                                         input logic signed [VALUE_W-1:0] v);
        item_in_t it;
        it.action = act;
        it.way = w[WAY_FIELD_W-1:0];
        it.value = v;
        return it;
    endfunction

    // offer one input transaction and hold it until accepted
    task automatic present(input item_in_t item, input bit live);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (live)
            items_sent++;
    endtask

    // wait until every result has left and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (due_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_ways(input logic [CNT_W-1:0] n);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // new ascending list for one way
    task automatic start_list(input int w);
        logic signed [VALUE_W-1:0] rnd;
        rem[w] = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 5);
        case ($urandom_range(0, 3))
            0: begin
                rnd = $urandom;
                cur_val[w] = rnd;
            end
            1: cur_val[w] = VALUE_MIN + longint'($urandom_range(0, 3));
            2: cur_val[w] = VALUE_MAX - longint'($urandom_range(0, 40));
            default: cur_val[w] = longint'($urandom_range(0, 20)) - 10;
        endcase
        case ($urandom_range(0, 3))
            0: stride[w] = 0;
            1: stride[w] = 2;
            2: stride[w] = 1000;
            default: stride[w] = 1 << 20;
        endcase
    endtask

    // next element of a way, or its end, sometimes after a stray transaction
    task automatic feed_way(input int w, input int n);
        int nw;
        if ($urandom_range(0, 11) == 0) begin
            if (n < WAYS && $urandom_range(0, 1) == 1) begin
                nw = $urandom_range(n, WAYS - 1);
                present(mk_item(1'($urandom_range(0, 1)), nw, $urandom), 1'b0);
            end
            else begin
                nw = $urandom_range(0, n - 1);
                present(mk_item(ACTION_DELIVER, nw, $urandom), 1'b1);
            end
        end
        if (rem[w] == 0)
            present(mk_item(ACTION_EXHAUST, w, $urandom), 1'b1);
        else begin
            present(mk_item(ACTION_DELIVER, w, cur_val[w][VALUE_W-1:0]), 1'b1);
            rem[w]--;
            cur_val[w] = cur_val[w] + longint'($urandom_range(0, stride[w]));
            if (cur_val[w] > VALUE_MAX)
                cur_val[w] = VALUE_MAX;
        end
    endtask

    // one full merge: fill every way, then refill whatever the block emits
    task automatic run_merge(input int n);
        int order [WAYS];
        int k;
        int tmp;
        int snap;
        int w;
        for (int i = 0; i < n; i++) begin
            start_list(i);
            order[i] = i;
        end
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        refill_q.delete();
        snap = done_seen;
        for (int i = 0; i < n; i++)
            feed_way(order[i], n);
        while (done_seen == snap) begin
            if ($urandom_range(0, 59) == 0) begin
                // hold off until the block has drained
                in_valid <= 1'b0;
                do @(negedge clk); while (due_count != 0);
            end
            else if (refill_q.size() != 0) begin
                w = refill_q.pop_front();
                feed_way(w, n);
            end
            else begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        refill_q.delete();
    endtask

    // unstructured transactions for broken sequences
    task automatic noise_burst(input int n, input int count);
        int w;
        repeat (count) begin
            w = $urandom_range(0, WAYS - 1);
            present(mk_item(1'($urandom_range(0, 1)), w, $urandom), w < n);
        end
    endtask

    initial begin : stimulus
        int               phase;
        int               n;
        int               j;
        logic [CNT_W-1:0] pick;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // two ways: extremes, dropped refills, inactive way, exhausted way
        set_ways(2);
        present(mk_item(ACTION_DELIVER, 0, 32'h7FFF_FFFF), 1'b1);
        present(mk_item(ACTION_DELIVER, 0, 32'sd5), 1'b1);
        present(mk_item(ACTION_DELIVER, 1, 32'h8000_0000), 1'b1);
        present(mk_item(ACTION_DELIVER, 5, 32'sd0), 1'b0);
        present(mk_item(ACTION_EXHAUST, 1, $urandom), 1'b1);
        present(mk_item(ACTION_DELIVER, 1, 32'sd3), 1'b1);
        present(mk_item(ACTION_DELIVER, 0, -32'sd1), 1'b1);
        present(mk_item(ACTION_EXHAUST, 0, $urandom), 1'b1);
        // equal heads, then exhaust a way that still holds its head
        present(mk_item(ACTION_DELIVER, 1, 32'sd7), 1'b1);
        present(mk_item(ACTION_DELIVER, 0, 32'sd7), 1'b1);
        present(mk_item(ACTION_EXHAUST, 1, $urandom), 1'b1);
        present(mk_item(ACTION_EXHAUST, 0, $urandom), 1'b1);
        present(mk_item(ACTION_EXHAUST, 15, $urandom), 1'b0);

        // lower the count while heads are held above it
        set_ways(4);
        present(mk_item(ACTION_DELIVER, 2, -32'sd1), 1'b1);
        present(mk_item(ACTION_DELIVER, 3, 32'sd100), 1'b1);
        present(mk_item(ACTION_DELIVER, 0, 32'sd50), 1'b1);
        set_ways(1);
        present(mk_item(ACTION_DELIVER, 1, 32'sd0), 1'b0);
        present(mk_item(ACTION_EXHAUST, 0, $urandom), 1'b1);
        set_ways(4);
        present(mk_item(ACTION_EXHAUST, 1, $urandom), 1'b1);
        present(mk_item(ACTION_DELIVER, 0, -32'sd5), 1'b1);
        present(mk_item(ACTION_EXHAUST, 0, $urandom), 1'b1);
        present(mk_item(ACTION_EXHAUST, 2, $urandom), 1'b1);
        present(mk_item(ACTION_EXHAUST, 3, $urandom), 1'b1);

        // zero ways: every transaction ends a merge
        set_ways(0);
        present(mk_item(ACTION_DELIVER, 3, $urandom), 1'b0);
        present(mk_item(ACTION_EXHAUST, 9, $urandom), 1'b0);

        // random merges over changing way counts
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            case (phase)
                0: pick = 5'd16;
                1: pick = 5'd1;
                2: pick = 5'd31;
                default: begin
                    case ($urandom_range(0, 7))
                        0: pick = 5'd0;
                        1: pick = 5'd2;
                        2: pick = 5'd16;
                        default: pick = CNT_W'($urandom_range(1, 16));
                    endcase
                end
            endcase
            set_ways(pick);
            if (pick == 0)
                repeat (6) present(mk_item(1'($urandom_range(0, 1)),
                                           $urandom_range(0, WAYS - 1), $urandom), 1'b0);
            else begin
                n = (pick > WAYS) ? WAYS : int'(pick);
                repeat ($urandom_range(1, 3)) run_merge(n);
                if ($urandom_range(0, 4) == 0)
                    noise_burst(n, 20);
            end
            phase++;
        end

        // drain and verdict
        in_valid <= 1'b0;
        j = 0;
        while (due_count != 0 && j < DRAIN_CYCLES) begin
            @(negedge clk);
            j++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (due_count != 0)
            $error("%0d merge results never arrived", due_count);
        if (fail_count == 0 && due_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/kwm_pkg.sv
design/kwm_front.sv
design/kwm_back.sv
design/k_way_sorted_merge.sv
bench/kwm_checker.sv
bench/tb_top.sv
